FILE: design/bucket_fifo_hash_table_core_defines.svh
// assertion macros shared by the bucket table modules
// no dependencies; every use expects clk and rst_n in scope
`ifndef BUCKET_FIFO_HASH_TABLE_CORE_DEFINES_SVH
`define BUCKET_FIFO_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BFHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bfht_pkg.sv
// shared types and constants of the bucket table
// no dependencies
package bfht_pkg;

    localparam int WAYS        = 16;
    localparam int BUCKETS     = 256;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int BUCKET_IN_W = 8;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int WAY_W       = $clog2(WAYS);
    localparam int FILL_W      = $clog2(WAYS + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // one bucket as stored in a memory row
    typedef struct packed {
        logic [FILL_W-1:0]            fill;
        logic [WAYS-1:0][KEY_W-1:0]   keys;
        logic [WAYS-1:0][VAL_W-1:0]   vals;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_t;

endpackage

FILE: design/bfht_if.sv
// request and response channels of the bucket table
// depends on bfht_pkg
interface bfht_req_if;
    import bfht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
    logic [BUCKET_IN_W-1:0] bucket;

    modport source (output valid, op, key, value, bucket, input ready);
    modport sink   (input valid, op, key, value, bucket, output ready);
endinterface

interface bfht_rsp_if;
    import bfht_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: design/bfht_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bfht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

FILE: design/bfht_ctrl.sv
// two-state sequencer: read a bucket row, then write it back on an insert and post the word
// depends on bfht_pkg and the assertion macro header
`include "bucket_fifo_hash_table_core_defines.svh"

module bfht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bfht_pkg::ctl_t ctl
);
    import bfht_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign ctl.capture = req_valid && req_ready;
    // commit only when the output register is free or being drained
    assign ctl.commit  = (state_reg == ST_CALC) && (!out_valid_reg || rsp_ready);
    assign rsp_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (ctl.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BFHT_ASSERT_NEXT(a_capture_to_calc, ctl.capture, state_reg == ST_CALC && !req_ready,
        "accepted word did not move to the compute state")
    `BFHT_ASSERT_NEXT(a_stall_holds_calc,
        state_reg == ST_CALC && out_valid_reg && !rsp_ready,
        state_reg == ST_CALC && out_valid_reg, "pending word lost during output stall")
    `BFHT_ASSERT_NOW(a_rsp_from_commit, $rose(out_valid_reg),
        $past(state_reg == ST_CALC), "response posted without a committed request")
endmodule

FILE: design/bfht_dp.sv
// bucket row memory, valid bits, insert/evict/lookup logic and result register
// depends on bfht_pkg and bfht_ram
module bfht_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bfht_pkg::ctl_t                   ctl,
    input  logic                             op,
    input  logic [bfht_pkg::KEY_W-1:0]       key,
    input  logic [bfht_pkg::VAL_W-1:0]       value,
    input  logic [bfht_pkg::BUCKET_IN_W-1:0] bucket,
    output logic                             hit,
    output logic [bfht_pkg::VAL_W-1:0]       read_value,
    output logic                             evicted,
    output logic [bfht_pkg::KEY_W-1:0]       evicted_key
);
    import bfht_pkg::*;

    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic             row_vld_reg;
    logic [BUCKETS-1:0] vld_reg;

    logic [BKT_W-1:0] rd_bkt;
    logic [ROW_W-1:0] rd_data;
    row_t             rd_row;
    row_t             wr_row;
    logic             wr_en;
    logic [FILL_W-1:0] fill;
    logic             full;
    logic             hit_c;
    logic [VAL_W-1:0] rv_c;

    // bucket count is a power of two, so the wrap is a part-select
    assign rd_bkt = bucket[BKT_W-1:0];

    bfht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (bkt_reg),
        .wr_data (wr_row),
        .rd_en   (ctl.capture),
        .rd_addr (rd_bkt),
        .rd_data (rd_data)
    );

    assign rd_row = row_t'(rd_data);
    // a never-written bucket reads as empty
    assign fill   = row_vld_reg ? rd_row.fill : '0;
    assign full   = (fill == FILL_W'(WAYS));
    assign wr_en  = ctl.commit && (op_reg == OP_INSERT);

    always_comb
    begin
        wr_row = rd_row;
        wr_row.fill = fill;
        if (full)
        begin
            for (int w = 0; w < WAYS - 1; w++)
            begin
                wr_row.keys[w] = rd_row.keys[w + 1];
                wr_row.vals[w] = rd_row.vals[w + 1];
            end
            wr_row.keys[WAYS-1] = key_reg;
            wr_row.vals[WAYS-1] = val_reg;
        end
        else
        begin
            wr_row.keys[fill[WAY_W-1:0]] = key_reg;
            wr_row.vals[fill[WAY_W-1:0]] = val_reg;
            wr_row.fill = fill + FILL_W'(1);
        end
    end

    // oldest match wins: scan from newest down so the lowest way lands last
    always_comb
    begin
        hit_c = 1'b0;
        rv_c  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if ((FILL_W'(w) < fill) && (rd_row.keys[w] == key_reg))
            begin
                hit_c = 1'b1;
                rv_c  = rd_row.vals[w];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg  <= op;
            key_reg <= key;
            val_reg <= value;
            bkt_reg <= rd_bkt;
        end
        if (ctl.commit)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                hit         <= hit_c;
                read_value  <= rv_c;
                evicted     <= 1'b0;
                evicted_key <= '0;
            end
            else
            begin
                hit         <= 1'b0;
                read_value  <= '0;
                evicted     <= full;
                evicted_key <= full ? rd_row.keys[0] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            row_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                row_vld_reg <= vld_reg[rd_bkt];
            end
            if (wr_en)
            begin
                vld_reg[bkt_reg] <= 1'b1;
            end
        end
    end
endmodule

FILE: design/bucket_fifo_hash_table_core.sv
// top level of the bucketized key-value table with oldest-first eviction
// depends on bfht_pkg, bfht_if, bfht_ctrl, bfht_dp and bfht_ram
//
// The table holds 256 buckets of 16 ways, each way a 64-bit key and a 64-bit
// value; the caller supplies the bucket index from its own hash. An insert
// takes the first free way of its bucket without checking for duplicates; in
// a full bucket the oldest way is dropped, the rest shift down and the new
// pair lands in the newest way, and the response reports the dropped key. A
// lookup returns the value of the oldest matching way, or a miss. Every
// request word yields exactly one response word. For each request the whole
// bucket row is read from a single-port-per-side row memory, then compared
// and, for an insert, updated and written back; this commit waits while a
// finished response still waits on rsp.ready, and the next request is taken
// only after the commit, so requests never overlap.
// req.ready is high whenever no request is in flight; a finished response
// sits in an output register, so a new request is taken while it waits.
// There is no clearing pass after reset: one valid bit per bucket marks
// buckets never written as empty.
module bucket_fifo_hash_table_core (
    input  logic        clk,
    input  logic        rst_n,
    bfht_req_if.sink    req,
    bfht_rsp_if.source  rsp
);
    import bfht_pkg::*;

    ctl_t ctl;

    // sequencer: handshakes and the read/commit commands
    bfht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    // datapath: bucket rows, valid bits and the response word register
    bfht_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .op          (req.op),
        .key         (req.key),
        .value       (req.value),
        .bucket      (req.bucket),
        .hit         (rsp.hit),
        .read_value  (rsp.read_value),
        .evicted     (rsp.evicted),
        .evicted_key (rsp.evicted_key)
    );
endmodule

FILE: bench/bfht_table_check_pkg.sv
// response word type and scoreboard for the bucket table bench
// depends on bfht_pkg
package bfht_table_check_pkg;
    import bfht_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_word_t;

    class bucket_table_scoreboard;
        logic [KEY_W-1:0] shadow_keys [BUCKETS*WAYS];
        logic [VAL_W-1:0] shadow_vals [BUCKETS*WAYS];
        int unsigned      shadow_fill [BUCKETS];
        rsp_word_t        pending_rsp [$];
        int unsigned      errors;

        function new();
            foreach (shadow_fill[i])
                shadow_fill[i] = 0;
            errors = 0;
        endfunction

        // update the shadow table and queue the response this request must produce
        function void note_request(logic op, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value,
                                   logic [BUCKET_IN_W-1:0] bucket);
            int unsigned b;
            int unsigned base;
            int unsigned fill;
            rsp_word_t   want;
            b    = int'(bucket) % BUCKETS;
            base = b * WAYS;
            fill = shadow_fill[b];
            want = '0;
            if (op == OP_INSERT)
            begin
                if (fill < WAYS)
                begin
                    shadow_keys[base + fill] = key;
                    shadow_vals[base + fill] = value;
                    shadow_fill[b]           = fill + 1;
                end
                else
                begin
                    // full bucket: drop the oldest way, shift down, append
                    want.evicted     = 1'b1;
                    want.evicted_key = shadow_keys[base];
                    for (int w = 0; w < WAYS - 1; w++)
                    begin
                        shadow_keys[base + w] = shadow_keys[base + w + 1];
                        shadow_vals[base + w] = shadow_vals[base + w + 1];
                    end
                    shadow_keys[base + WAYS - 1] = key;
                    shadow_vals[base + WAYS - 1] = value;
                end
            end
            else
            begin
                for (int w = 0; w < fill; w++)
                begin
                    if (shadow_keys[base + w] == key)
                    begin
                        want.hit        = 1'b1;
                        want.read_value = shadow_vals[base + w];
                        break;
                    end
                end
            end
            pending_rsp.push_back(want);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_response(rsp_word_t got);
            rsp_word_t want;
            if (pending_rsp.size() == 0)
            begin
                report($sformatf("unexpected response hit=%0b value=%h evicted=%0b key=%h",
                                 got.hit, got.read_value, got.evicted, got.evicted_key));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %h, expected %h",
                                 got.read_value, want.read_value));
            if (got.evicted !== want.evicted)
                report($sformatf("evicted %0b, expected %0b", got.evicted, want.evicted));
            if (got.evicted_key !== want.evicted_key)
                report($sformatf("evicted_key %h, expected %h",
                                 got.evicted_key, want.evicted_key));
        endtask
    endclass

endpackage

FILE: bench/bucket_fifo_hash_table_core_test.sv
// top of the bucket table bench: clock, reset, request driver, response checking
// depends on bfht_pkg, bfht_if, bfht_table_check_pkg and the bucket table rtl
module bucket_fifo_hash_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfht_pkg::*;
    import bfht_table_check_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RECENT_DEPTH = 48;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycles = 0;

    // idle rates in percent, changed between phases
    int unsigned send_idle_pct = 18;
    int unsigned rsp_idle_pct  = 75;

    // handshake state sampled at the falling edge, acted on at the next rising edge
    logic        req_go = 1'b0;
    logic        rsp_go = 1'b0;
    rsp_word_t   rsp_seen;

    // recently inserted keys, so lookups find something
    logic [KEY_W-1:0]       recent_keys [$];
    logic [BUCKET_IN_W-1:0] recent_buckets [$];

    bucket_table_scoreboard table_sb = new();

    bfht_req_if req_ch ();
    bfht_rsp_if rsp_ch ();

    bucket_fifo_hash_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // outputs settle after the rising edge and inputs only move on it,
    // so the falling edge sees exactly what the next rising edge will take
    always @(negedge clk)
    begin
        req_go   = rst_n && req_ch.valid && req_ch.ready;
        rsp_go   = rst_n && rsp_ch.valid && rsp_ch.ready;
        rsp_seen = {rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key};
    end

    // every accepted response word is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rsp_go)
            table_sb.check_response(rsp_seen);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // response side: ready drops at random at the current stall rate
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // present one request word, hold it until taken, then predict its response
    task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                             logic [BUCKET_IN_W-1:0] bucket);
        // random gap before the word; valid stays high across back-to-back words
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.key    <= key;
        req_ch.value  <= value;
        req_ch.bucket <= bucket;
        do
            @(posedge clk);
        while (!req_go);
        table_sb.note_request(op, key, value, bucket);
        if (op == OP_INSERT)
        begin
            recent_keys.push_back(key);
            recent_buckets.push_back(bucket);
            if (recent_keys.size() > RECENT_DEPTH)
            begin
                void'(recent_keys.pop_front());
                void'(recent_buckets.pop_front());
            end
        end
    endtask

    // random traffic: mostly inserts into a few busy buckets and lookups of
    // recent keys, with some fully random words as noise
    task automatic run_random(int unsigned count);
        logic [KEY_W-1:0]       key;
        logic [BUCKET_IN_W-1:0] bucket;
        int unsigned            pick;
        int unsigned            idx;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 42 || (pick < 85 && recent_keys.size() == 0))
            begin
                // busy buckets fill up fast and then evict on every insert
                if ($urandom_range(9) < 8)
                    bucket = BUCKET_IN_W'($urandom_range(5));
                else
                    bucket = BUCKET_IN_W'($urandom());
                // small keys give duplicates, all ones is a legal key too
                case ($urandom_range(7))
                    0, 1:    key = KEY_W'($urandom_range(7));
                    2:       key = '1;
                    default: key = rand64();
                endcase
                send_word(OP_INSERT, key, rand64(), bucket);
            end
            else if (pick < 85)
            begin
                idx = $urandom_range(recent_keys.size() - 1);
                key = recent_keys[idx];
                // occasional near miss on the lowest key bit
                if ($urandom_range(9) == 0)
                    key = key ^ KEY_W'(1);
                send_word(OP_LOOKUP, key, rand64(), recent_buckets[idx]);
            end
            else
            begin
                send_word(($urandom_range(1) == 0) ? OP_INSERT : OP_LOOKUP,
                          rand64(), rand64(), BUCKET_IN_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.op     <= OP_INSERT;
        req_ch.key    <= '0;
        req_ch.value  <= '0;
        req_ch.bucket <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        // an empty bucket never hits, not even on key zero
        send_word(OP_LOOKUP, '0, '0, 8'd0);
        send_word(OP_INSERT, '0, '1, 8'd0);
        // all-ones key is an ordinary key, not an empty marker
        send_word(OP_INSERT, '1, '0, 8'd0);
        // duplicate insert lands in its own way
        send_word(OP_INSERT, '1, 64'h5, 8'd0);
        // lookup returns the oldest copy of a duplicate
        send_word(OP_LOOKUP, '1, '1, 8'd0);
        send_word(OP_LOOKUP, '0, '0, 8'd0);
        // miss in an occupied bucket
        send_word(OP_LOOKUP, 64'h123, '0, 8'd0);
        // fill bucket zero to the last way
        for (int i = 0; i < 13; i++)
            send_word(OP_INSERT, 64'h100 + i, {32'hdead_beef, 32'(i)}, 8'd0);
        // full bucket: key zero is evicted
        send_word(OP_INSERT, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa, 8'd0);
        send_word(OP_LOOKUP, '0, '0, 8'd0);
        send_word(OP_LOOKUP, '1, '0, 8'd0);
        // highest bucket index
        send_word(OP_INSERT, 64'h8000_0000_0000_0001, '1, 8'd255);
        send_word(OP_LOOKUP, 64'h8000_0000_0000_0001, '0, 8'd255);

        // slow receiver
        run_random(RANDOM_WORDS / 3);
        // slow sender
        send_idle_pct = 75;
        rsp_idle_pct  = 18;
        run_random(RANDOM_WORDS / 3);
        // full rate both sides
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        req_ch.valid <= 1'b0;

        // drain, then give any stray response a chance to show up
        while (table_sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
